>>> hdl/indexed_insert_delete_list_unit_macros.svh
// ----------------------------------------------------------------------------
// Indexed insert/delete list unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_LIST_UNIT_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define IIDL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define IIDL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/iidl_pkg.sv
// ----------------------------------------------------------------------------
// Indexed insert/delete list package
// Field widths, command and status codes, and the broadcast cell control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iidl_pkg;

	localparam int CMD_W        = 3;
	localparam int POS_W        = 8;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 2;
	localparam int LEN_W        = 7;
	localparam int CAPACITY_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_GET        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INS_AT     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_AT     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic              rd;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/iidl_cell.sv
// ----------------------------------------------------------------------------
// Indexed insert/delete list cell
// Holds one list entry and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iidl_cell #(
	parameter int IDX = 0
) (
	input  wire logic                         clk,
	input  wire iidl_pkg::cell_ctrl_t         ctrl,
	input  wire logic [iidl_pkg::DATA_W-1:0]  left_value,
	input  wire logic [iidl_pkg::DATA_W-1:0]  right_value,
	output logic      [iidl_pkg::DATA_W-1:0]  value,
	output logic      [iidl_pkg::DATA_W-1:0]  rd_term
);

	localparam logic [iidl_pkg::POS_W-1:0] MY_POS = iidl_pkg::POS_W'(IDX);

	logic [iidl_pkg::DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_POS == ctrl.pos) begin
				value_q <= ctrl.value;
			end else if (MY_POS > ctrl.pos) begin
				value_q <= left_value;
			end
		end else if (ctrl.del) begin
			if (MY_POS >= ctrl.pos) begin
				value_q <= right_value;
			end
		end
	end

	assign value   = value_q;
	assign rd_term = (ctrl.rd && (MY_POS == ctrl.pos)) ? value_q : '0;

endmodule

`default_nettype wire

>>> hdl/indexed_insert_delete_list_unit.sv
// ----------------------------------------------------------------------------
// Indexed insert/delete list unit
// Ordered list of signed 32-bit entries held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Result: a start transfer is registered in valid_s1 and then in done_q; the
// result strobe done is high for exactly one cycle.
// Throughput: one command per cycle; busy stays low, since every cell shifts
// in parallel and a get reads through one OR reduction across the row.
// Reset: arst_n clears the entry count and the pipeline valid flags; entry
// cells are not cleared. The receiver cannot stall, so no result is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_insert_delete_list_unit_macros.svh"

module indexed_insert_delete_list_unit #(
	parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic        [iidl_pkg::CMD_W-1:0]    cmd,
	input  wire logic        [iidl_pkg::POS_W-1:0]    position,
	input  wire logic signed [iidl_pkg::DATA_W-1:0]   item_value,
	output logic                                     done,
	output logic signed      [iidl_pkg::DATA_W-1:0]   read_value,
	output logic             [iidl_pkg::STATUS_W-1:0] status,
	output logic             [iidl_pkg::LEN_W-1:0]    length
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > iidl_pkg::POS_W) ? CNT_W : iidl_pkg::POS_W;

	logic                            valid_s1;
	logic [iidl_pkg::CMD_W-1:0]      cmd_s1;
	logic [iidl_pkg::POS_W-1:0]      pos_s1;
	logic [iidl_pkg::DATA_W-1:0]     value_s1;

	logic [CNT_W-1:0]                count_q;
	logic                            done_q;
	logic [iidl_pkg::DATA_W-1:0]     read_value_q;
	logic [iidl_pkg::STATUS_W-1:0]   status_q;

	iidl_pkg::cell_ctrl_t            ctrl;
	logic [CMP_W-1:0]                cnt_c;
	logic [CMP_W-1:0]                pos_c;
	logic [CMP_W-1:0]                at_c;
	logic                            ins_req;
	logic                            get_ok;
	logic [iidl_pkg::STATUS_W-1:0]   status_c;
	logic [CNT_W-1:0]                count_c;
	logic [iidl_pkg::DATA_W-1:0]     rd_or;

	logic [iidl_pkg::DATA_W-1:0]     cell_value [CAPACITY];
	logic [iidl_pkg::DATA_W-1:0]     rd_term    [CAPACITY];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1   <= cmd;
			pos_s1   <= position;
			value_s1 <= item_value;
		end
	end

	always_comb begin
		cnt_c    = CMP_W'(count_q);
		pos_c    = CMP_W'(pos_s1);
		at_c     = pos_c;
		ins_req  = 1'b0;
		get_ok   = pos_c < cnt_c;
		status_c = iidl_pkg::ST_DONE;
		count_c  = count_q;
		ctrl     = '0;
		ctrl.value = value_s1;
		unique case (cmd_s1)
			iidl_pkg::CMD_GET: begin
				ctrl.rd  = valid_s1;
				ctrl.pos = pos_s1;
				if (!get_ok) begin
					status_c = iidl_pkg::ST_RANGE;
				end
			end
			iidl_pkg::CMD_INS_HEAD: begin
				ins_req = 1'b1;
				at_c    = '0;
			end
			iidl_pkg::CMD_INS_TAIL: begin
				ins_req = 1'b1;
				at_c    = cnt_c;
			end
			iidl_pkg::CMD_INS_AT: begin
				ins_req = 1'b1;
				at_c    = pos_c;
			end
			iidl_pkg::CMD_DEL_AT: begin
				ctrl.pos = pos_s1;
				if (!get_ok) begin
					status_c = iidl_pkg::ST_RANGE;
				end else begin
					ctrl.del = valid_s1;
					count_c  = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (ins_req) begin
			ctrl.pos = iidl_pkg::POS_W'(at_c);
			if (at_c > cnt_c) begin
				status_c = iidl_pkg::ST_RANGE;
			end else if (cnt_c >= CMP_W'(CAPACITY)) begin
				status_c = iidl_pkg::ST_FULL;
			end else begin
				ctrl.ins = valid_s1;
				count_c  = count_q + 1'b1;
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [iidl_pkg::DATA_W-1:0] left_value;
		logic [iidl_pkg::DATA_W-1:0] right_value;

		if (g == 0) begin : g_first
			assign left_value = '0;
		end else begin : g_inner_l
			assign left_value = cell_value[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_value = '0;
		end else begin : g_inner_r
			assign right_value = cell_value[g+1];
		end

		iidl_cell #(
			.IDX(g)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (cell_value[g]),
			.rd_term     (rd_term[g])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | rd_term[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				count_q <= count_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_c;
			if (cmd_s1 == iidl_pkg::CMD_GET) begin
				read_value_q <= get_ok ? rd_or : '1;
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = iidl_pkg::LEN_W'(count_q);

	`IIDL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count over capacity")
	`IIDL_ASSERT_NEXT(a_result_follows, valid_s1, done, "command gave no result")
	`IIDL_ASSERT_SAME(a_full_at_capacity, done && (status == iidl_pkg::ST_FULL), count_q == CNT_W'(CAPACITY), "full status below capacity")
	`IIDL_ASSERT_NEXT(a_no_change_idle, !valid_s1, $stable(count_q), "entry count moved without a command")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/delete list unit testbench
// Drives get, insert and delete commands through the start/busy handshake,
// predicts every result with a mirror of the list, and compares each done
// strobe field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module testbench;

	import iidl_pkg::*;

	localparam int LIST_CAP    = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SEG_ITEMS   = 40;
	localparam int SEG_COUNT   = 11;

	typedef struct {
		logic        [CMD_W-1:0]  cmd;
		logic        [POS_W-1:0]  pos;
		logic signed [DATA_W-1:0] value;
		int                       idle_pct;
		bit                       drain;
	} list_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0]   read_value;
		logic        [STATUS_W-1:0] status;
		logic        [LEN_W-1:0]    length;
	} list_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic        [CMD_W-1:0]    cmd = '0;
	logic        [POS_W-1:0]    position = '0;
	logic signed [DATA_W-1:0]   item_value = '0;
	logic                       busy;
	logic                       done;
	logic signed [DATA_W-1:0]   read_value;
	logic        [STATUS_W-1:0] status;
	logic        [LEN_W-1:0]    length;

	list_cmd_t    pending_cmds[$];
	list_result_t list_results_due[$];

	logic signed [DATA_W-1:0] mirror_cells [0:LIST_CAP-1];
	int  mirror_len = 0;
	int  planned_len = 0;
	int  seg_idle = 0;
	bit  seg_drain = 1'b0;
	int  item_total = 0;
	int  accepted_total = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;

	indexed_insert_delete_list_unit #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.position(position),
		.item_value(item_value),
		.done(done),
		.read_value(read_value),
		.status(status),
		.length(length)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic list_result_t apply_list_command(logic [CMD_W-1:0] c,
			logic [POS_W-1:0] p, logic signed [DATA_W-1:0] v);
		list_result_t r;
		int at;
		bit is_insert;
		r.read_value = '0;
		r.status = ST_DONE;
		is_insert = 1'b0;
		at = 0;
		case (c)
			CMD_GET: begin
				if (p < mirror_len) begin
					r.read_value = mirror_cells[p];
				end else begin
					r.read_value = -1;
					r.status = ST_RANGE;
				end
			end
			CMD_INS_HEAD: begin
				is_insert = 1'b1;
				at = 0;
			end
			CMD_INS_TAIL: begin
				is_insert = 1'b1;
				at = mirror_len;
			end
			CMD_INS_AT: begin
				is_insert = 1'b1;
				at = p;
			end
			CMD_DEL_AT: begin
				if (p >= mirror_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = p; i + 1 < mirror_len; i++)
						mirror_cells[i] = mirror_cells[i + 1];
					mirror_len--;
				end
			end
			default: ;
		endcase
		if (is_insert) begin
			if (at > mirror_len) begin
				r.status = ST_RANGE;
			end else if (mirror_len >= LIST_CAP) begin
				r.status = ST_FULL;
			end else begin
				for (int i = mirror_len; i > at; i--)
					mirror_cells[i] = mirror_cells[i - 1];
				mirror_cells[at] = v;
				mirror_len++;
			end
		end
		r.length = mirror_len[LEN_W-1:0];
		return r;
	endfunction

	// Tracks only the list length while the stimulus is planned, so that
	// positions can be aimed at the live part of the list.
	task automatic add_cmd(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
			logic signed [DATA_W-1:0] v);
		list_cmd_t item;
		item.cmd = c;
		item.pos = p;
		item.value = v;
		item.idle_pct = seg_idle;
		item.drain = seg_drain;
		seg_drain = 1'b0;
		pending_cmds.push_back(item);
		item_total++;
		case (c)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (planned_len < LIST_CAP)
					planned_len++;
			end
			CMD_INS_AT: begin
				if (p <= planned_len && planned_len < LIST_CAP)
					planned_len++;
			end
			CMD_DEL_AT: begin
				if (p < planned_len)
					planned_len--;
			end
			default: ;
		endcase
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position(bit allow_end);
		if (planned_len == 0 && !allow_end)
			return '0;
		return POS_W'($urandom_range(planned_len - 1 + int'(allow_end)));
	endfunction

	task automatic add_random_cmd(bit grow);
		int r;
		int ins_end;
		r = $urandom_range(99);
		ins_end = grow ? 85 : 40;
		if (r < 5) begin
			add_cmd(CMD_W'($urandom_range(7)), POS_W'($urandom_range(255)), pick_value());
		end else if (r < 25) begin
			add_cmd(CMD_GET, pick_position(1'b0), pick_value());
		end else if (r < ins_end) begin
			case ($urandom_range(3))
				0: add_cmd(CMD_INS_HEAD, POS_W'($urandom_range(255)), pick_value());
				1: add_cmd(CMD_INS_TAIL, POS_W'($urandom_range(255)), pick_value());
				default: add_cmd(CMD_INS_AT, pick_position(1'b1), pick_value());
			endcase
		end else begin
			add_cmd(CMD_DEL_AT, pick_position(1'b0), pick_value());
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_cmd_t nxt;
		bit launch;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			position <= '0;
			item_value <= '0;
		end else begin
			if (start && !busy) begin
				list_results_due.push_back(apply_list_command(cmd, position, item_value));
				accepted_total++;
			end
			if (!(start && busy)) begin
				launch = pending_cmds.size() != 0
					&& (!pending_cmds[0].drain || list_results_due.size() == 0)
					&& $urandom_range(99) >= pending_cmds[0].idle_pct;
				if (launch) begin
					nxt = pending_cmds.pop_front();
					start <= 1'b1;
					cmd <= nxt.cmd;
					position <= nxt.pos;
					item_value <= nxt.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string field, logic [DATA_W-1:0] exp_val,
			logic [DATA_W-1:0] act_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s expected %h, got %h", $realtime, field, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n && done) begin
			if (list_results_due.size() == 0) begin
				report_mismatch("unexpected result, read_value", 'x, read_value);
			end else begin
				exp_res = list_results_due.pop_front();
				if (read_value !== exp_res.read_value)
					report_mismatch("read_value", exp_res.read_value, read_value);
				if (status !== exp_res.status)
					report_mismatch("status", exp_res.status, status);
				if (length !== exp_res.length)
					report_mismatch("length", exp_res.length, length);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("indexed_insert_delete_list_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int idle_sched [3];
		idle_sched = '{0, 87, 36};

		// Empty list, out-of-range positions, value extremes, unused codes.
		add_cmd(CMD_GET, 8'd0, '0);
		add_cmd(CMD_DEL_AT, 8'd0, '0);
		add_cmd(CMD_INS_AT, 8'd1, 32'sh1234_5678);
		add_cmd(CMD_INS_AT, 8'd0, 32'sh7fff_ffff);
		add_cmd(CMD_INS_HEAD, 8'd0, 32'sh8000_0000);
		add_cmd(CMD_INS_TAIL, 8'd255, -1);
		add_cmd(CMD_INS_AT, 8'd1, '0);
		add_cmd(CMD_INS_AT, 8'd4, 32'sh5555_5555);
		add_cmd(CMD_INS_AT, 8'd255, 32'sh0bad_f00d);
		add_cmd(CMD_GET, 8'd0, '0);
		add_cmd(CMD_GET, 8'd4, -1);
		add_cmd(CMD_GET, 8'd5, '0);
		add_cmd(CMD_GET, 8'd255, '0);
		add_cmd(CMD_DEL_AT, 8'd255, '0);
		add_cmd(CMD_DEL_AT, 8'd2, '0);
		add_cmd(CMD_DEL_AT, 8'd3, '0);
		add_cmd(CMD_DEL_AT, 8'd0, '0);
		add_cmd(3'd5, 8'd0, '0);
		add_cmd(3'd6, 8'd128, -1);
		add_cmd(3'd7, 8'd255, 32'shaaaa_aaaa);
		add_cmd(CMD_GET, 8'd1, '0);
		add_cmd(CMD_GET, 8'd2, '0);

		// Fill to capacity and hammer the full list, drain to empty, repeat.
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			seg_idle = idle_sched[seg % 3];
			seg_drain = 1'b1;
			for (int k = 0; k < SEG_ITEMS; k++)
				add_random_cmd(seg < 4 || seg == 7 || seg == 8);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_total < item_total || list_results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("indexed_insert_delete_list_unit: match");
		end else begin
			$display("indexed_insert_delete_list_unit: mismatch");
		end
		$finish;
	end

endmodule
